>>> rtl/mrpt_pkg.sv
// Shared constants for the Miller-Rabin prime test block.
// Holds the witness base table and the default operand width.
// Depends on nothing; used by mrpt_mulmod and miller_rabin_prime_test.
package mrpt_pkg;

    // Width of the candidate port and default working width.
    localparam int CAND_W    = 64;
    localparam int WIDTH_DEF = 64;

    // The first twelve primes serve as witness bases.
    localparam int NUM_BASES = 12;
    localparam int BASE_W    = 6;
    localparam int K_W       = $clog2(NUM_BASES);

    localparam logic [BASE_W-1:0] MR_BASES [NUM_BASES] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
        6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

endpackage

>>> rtl/miller_rabin_prime_test.sv
// Deterministic Miller-Rabin primality test, top level.
// Depends on mrpt_pkg and mrpt_mulmod.
//
// Each item carries one unsigned candidate; the low WIDTH bits are tested against the
// witness bases 2 through 37, which is exact for every value below 2^64, and one item
// with is_prime comes back. The block works on one candidate at a time. All modular
// products go through a single shared bit-serial shift-and-add multiplier that takes
// one multiplier bit per cycle. Each base costs up to about 2*WIDTH products for the
// exponentiation plus up to s-1 squarings, so small, even and most composite
// candidates finish far sooner than a large prime. A finished result is held in an
// output register, and a new candidate may be taken while it waits.
module miller_rabin_prime_test #(
    parameter int WIDTH = mrpt_pkg::WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mrpt_pkg::CAND_W-1:0] i_candidate,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_is_prime
);

    import mrpt_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [K_W-1:0] LAST_K = K_W'(NUM_BASES - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SPLIT = 12'b0000_0000_0010,
        S_BASE  = 12'b0000_0000_0100,
        S_BRED  = 12'b0000_0000_1000,
        S_PSTEP = 12'b0000_0001_0000,
        S_PMR   = 12'b0000_0010_0000,
        S_PMB   = 12'b0000_0100_0000,
        S_WCHK  = 12'b0000_1000_0000,
        S_SQCHK = 12'b0001_0000_0000,
        S_SQMUL = 12'b0010_0000_0000,
        S_NEXT  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] n_n;
    logic [WIDTH-1:0] r_nm1;
    logic [WIDTH-1:0] n_nm1;
    logic [WIDTH-1:0] r_d;
    logic [WIDTH-1:0] n_d;
    logic [CNT_W-1:0] r_s;
    logic [CNT_W-1:0] n_s;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] n_i;
    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   n_k;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] n_b;
    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] n_r;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] n_e;
    logic             r_res;
    logic             n_res;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_out_prime;
    logic             n_out_prime;

    logic             mm_start;
    logic [WIDTH-1:0] mm_x;
    logic [WIDTH-1:0] mm_y;
    logic             mm_done;
    logic [WIDTH-1:0] mm_res;
    logic [WIDTH-1:0] base_k;
    logic             out_load;

    // Shared modular multiplier.
    mrpt_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_x      (mm_x),
        .i_y      (mm_y),
        .i_n      (r_n),
        .o_done   (mm_done),
        .o_result (mm_res)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;
    assign base_k     = WIDTH'(MR_BASES[r_k]);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // Test sequencer: split n-1, walk the bases, exponentiate, then square for n-1.
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_nm1    = r_nm1;
        n_d      = r_d;
        n_s      = r_s;
        n_i      = r_i;
        n_k      = r_k;
        n_b      = r_b;
        n_r      = r_r;
        n_e      = r_e;
        n_res    = r_res;
        mm_start = 1'b0;
        mm_x     = r_b;
        mm_y     = r_r;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n     = i_candidate[WIDTH-1:0];
                    n_nm1   = i_candidate[WIDTH-1:0] - WIDTH'(1);
                    n_d     = i_candidate[WIDTH-1:0] - WIDTH'(1);
                    n_s     = '0;
                    n_k     = '0;
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (r_n < WIDTH'(2)) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_s = r_s + CNT_W'(1);
                end else begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                if (r_n == base_k) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_b     = base_k;
                    n_state = S_BRED;
                end
            end
            S_BRED: begin
                // Reduce the base below n by repeated subtraction (only for tiny n).
                if (r_b >= r_n) begin
                    n_b = r_b - r_n;
                end else begin
                    n_r     = WIDTH'(1);
                    n_e     = r_d;
                    n_state = S_PSTEP;
                end
            end
            S_PSTEP: begin
                if (r_e == '0) begin
                    n_state = S_WCHK;
                end else if (r_e[0]) begin
                    mm_start = 1'b1;
                    mm_x     = r_b;
                    mm_y     = r_r;
                    n_state  = S_PMR;
                end else begin
                    mm_start = 1'b1;
                    mm_x     = r_b;
                    mm_y     = r_b;
                    n_state  = S_PMB;
                end
            end
            S_PMR: begin
                if (mm_done) begin
                    n_r = mm_res;
                    if (r_e[WIDTH-1:1] == '0) begin
                        // Last exponent bit: the final squaring of the base is not needed.
                        n_e     = '0;
                        n_state = S_WCHK;
                    end else begin
                        mm_start = 1'b1;
                        mm_x     = r_b;
                        mm_y     = r_b;
                        n_state  = S_PMB;
                    end
                end
            end
            S_PMB: begin
                if (mm_done) begin
                    n_b     = mm_res;
                    n_e     = r_e >> 1;
                    n_state = S_PSTEP;
                end
            end
            S_WCHK: begin
                if ((r_r == WIDTH'(1)) || (r_r == r_nm1)) begin
                    n_state = S_NEXT;
                end else begin
                    n_i     = CNT_W'(1);
                    n_state = S_SQCHK;
                end
            end
            S_SQCHK: begin
                if (r_i < r_s) begin
                    mm_start = 1'b1;
                    mm_x     = r_r;
                    mm_y     = r_r;
                    n_state  = S_SQMUL;
                end else begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_SQMUL: begin
                if (mm_done) begin
                    n_r = mm_res;
                    if (mm_res == r_nm1) begin
                        n_state = S_NEXT;
                    end else begin
                        n_i     = r_i + CNT_W'(1);
                        n_state = S_SQCHK;
                    end
                end
            end
            S_NEXT: begin
                if (r_k == LAST_K) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + K_W'(1);
                    n_state = S_BASE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: holds the result item until it is taken.
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_prime = r_out_prime;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_prime = r_res;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_nm1       <= n_nm1;
        r_d         <= n_d;
        r_s         <= n_s;
        r_i         <= n_i;
        r_b         <= n_b;
        r_r         <= n_r;
        r_e         <= n_e;
        r_res       <= n_res;
        r_out_prime <= n_out_prime;
    end

`ifndef SYNTHESIS
    // The base index never runs past the last base.
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= LAST_K)
        else $error("base index beyond the base table");

    // Every product is started on residues already reduced below n.
    a_mul_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_start |-> ((mm_x < r_n) && (mm_y < r_n)))
        else $error("modular product started on unreduced operand");

    // A finished test shows up on the output with its verdict.
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && (o_is_prime == $past(r_res))))
        else $error("finished result not presented on the output");
`endif

endmodule

>>> rtl/mrpt_mulmod.sv
// Bit-serial modular multiplier: x * y mod n by shift-and-add.
// The multiplier operand is shifted out one bit per cycle.
// Depends on mrpt_pkg for the default width.
module mrpt_mulmod #(
    parameter int WIDTH = mrpt_pkg::WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_n,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);

    logic             r_run;
    logic             n_run;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] n_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] n_y;

    // Modular addition of two residues below n: one add, one compare and subtract.
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] n);
        logic [WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, n}) begin
            sum = sum - {1'b0, n};
        end
        return sum[WIDTH-1:0];
    endfunction

    // The product is ready once every multiplier bit has been consumed.
    assign o_done   = r_run && (r_y == '0);
    assign o_result = r_acc;

    // One multiplier bit per cycle: add the multiplicand when the bit is set, then double it.
    always_comb begin
        n_run = r_run;
        n_acc = r_acc;
        n_x   = r_x;
        n_y   = r_y;
        if (i_start) begin
            n_run = 1'b1;
            n_acc = '0;
            n_x   = i_x;
            n_y   = i_y;
        end else if (r_run) begin
            if (r_y == '0) begin
                n_run = 1'b0;
            end else begin
                if (r_y[0]) begin
                    n_acc = add_mod(r_acc, r_x, i_n);
                end
                n_x = add_mod(r_x, r_x, i_n);
                n_y = r_y >> 1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= n_run;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

`ifndef SYNTHESIS
    // A new product is started only when the unit is idle or just finishing.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_run || (r_y == '0)))
        else $error("mulmod started while a product is in progress");

    // Accumulator and multiplicand stay reduced while a product runs.
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> ((r_acc < i_n) && (r_x < i_n)))
        else $error("mulmod residue not reduced below modulus");

    // The modulus does not change under a running product.
    a_mod_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && $past(r_run)) |-> $stable(i_n))
        else $error("mulmod modulus changed during a product");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for miller_rabin_prime_test: a directed table of candidates, a back-pressure
// burst and four idling phases of random items, checked by known answers or a predictor.
// Depends on mrpt_pkg and the RTL of the block; reads and writes no files.
module tb;

    localparam int DUT_W       = mrpt_pkg::WIDTH_DEF;
    localparam int CW          = mrpt_pkg::CAND_W;
    localparam int PHASE_ITEMS = 18;
    localparam int BURST_ITEMS = 8;
    localparam int HOLD_CYCLES = 40000;
    localparam int TAIL_CYCLES = 200;
    localparam int SHOW_MAX    = 10;
    localparam int NUM_ROWS    = 23;
    // Even a worst-case stimulus stays far below this limit.
    localparam longint unsigned LIMIT_CYCLES = 100_000_000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum logic [2:0] {
        SHAPE_TINY, SHAPE_HALF, SHAPE_WORD, SHAPE_WIDE,
        SHAPE_SEMIPRIME, SHAPE_PRIME, SHAPE_CARMICHAEL
    } t_shape;

    typedef struct packed {
        logic [63:0] cand;
        logic        prime;
    } t_verdict;

    typedef struct packed {
        logic [63:0] cand;
        logic        known;
        logic        prime;
    } t_row;

    // Rows with known set carry an answer that is plain by inspection.
    t_row directed_rows [NUM_ROWS] = '{
        '{64'd0, 1'b1, 1'b0},                        // zero is not prime
        '{64'd1, 1'b1, 1'b0},                        // one is not prime
        '{64'd2, 1'b1, 1'b1},                        // equal to the first base
        '{64'd3, 1'b1, 1'b1},
        '{64'd13, 1'b1, 1'b1},
        '{64'd37, 1'b1, 1'b1},                       // equal to the last base
        '{64'd4, 1'b1, 1'b0},                        // even above two
        '{64'h8000_0000_0000_0000, 1'b1, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0},      // all ones, divisible by three
        '{64'd9, 1'b0, 1'b0},                        // odd square, several squarings
        '{64'd41, 1'b0, 1'b0},                       // smallest prime past the bases
        '{64'd561, 1'b0, 1'b0},                      // Carmichael number
        '{64'd2047, 1'b0, 1'b0},                     // strong liar for base 2
        '{64'd1373653, 1'b0, 1'b0},                  // liar for bases 2 and 3
        '{64'd25326001, 1'b0, 1'b0},                 // liar up to base 5
        '{64'd3215031751, 1'b0, 1'b0},               // liar up to base 7
        '{64'd2152302898747, 1'b0, 1'b0},            // liar up to base 11
        '{64'd3474749660383, 1'b0, 1'b0},            // liar up to base 13
        '{64'd341550071728321, 1'b0, 1'b0},          // liar up to base 17
        '{64'd3825123056546413051, 1'b0, 1'b0},      // liar up to base 23
        '{64'h1FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},      // Mersenne prime
        '{64'd18446744073709551557, 1'b0, 1'b0}      // largest prime below 2^64
    };

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic [CW-1:0] i_candidate = '0;
    logic          i_ready     = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic          o_is_prime;

    t_idle            idle_mode    = IDLE_NONE;
    logic             hold_request = 1'b0;
    logic             hold_active  = 1'b0;
    t_verdict         pending_verdicts [$];
    int unsigned      mismatches   = 0;
    int unsigned      items_sent   = 0;
    int unsigned      results_seen = 0;
    int unsigned      primes_seen  = 0;
    longint unsigned  cycle_count  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    miller_rabin_prime_test #(
        .WIDTH(DUT_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_candidate(i_candidate),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_is_prime (o_is_prime)
    );

    // (a + b) mod n for a, b below n, without overflowing 64 bits.
    function automatic logic [63:0] sum_mod(input logic [63:0] a, b, n);
        logic [63:0] gap;
        gap = n - b;
        return (a >= gap) ? a - gap : a + b;
    endfunction

    // (x * y) mod n by shift-and-add.
    function automatic logic [63:0] product_mod(input logic [63:0] x, y, n);
        logic [63:0] acc;
        acc = '0;
        x = x % n;
        y = y % n;
        while (y != 0) begin
            if (y[0]) acc = sum_mod(acc, x, n);
            x = sum_mod(x, x, n);
            y = y >> 1;
        end
        return acc;
    endfunction

    // (b ^ e) mod n by square-and-multiply.
    function automatic logic [63:0] power_mod(input logic [63:0] b, e, n);
        logic [63:0] acc;
        acc = 64'd1;
        b = b % n;
        while (e != 0) begin
            if (e[0]) acc = product_mod(b, acc, n);
            b = product_mod(b, b, n);
            e = e >> 1;
        end
        return acc;
    endfunction

    // True when base a proves n composite, with n - 1 = 2^s * d.
    function automatic logic base_shows_composite(input logic [63:0] n, a, d,
                                                  input int unsigned s);
        logic [63:0] x;
        int unsigned i;
        x = power_mod(a, d, n);
        if (x == 64'd1 || x == n - 64'd1) return 1'b0;
        for (i = 1; i < s; i++) begin
            x = product_mod(x, x, n);
            if (x == n - 64'd1) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Expected is_prime for one candidate, tested at the block's width.
    function automatic logic predict_prime(input logic [63:0] cand);
        logic [63:0] n, d, a, mask;
        int unsigned s;
        int          k;
        mask = (DUT_W >= 64) ? {64{1'b1}} : ((64'd1 << DUT_W) - 64'd1);
        n = cand & mask;
        if (n < 64'd2) return 1'b0;
        d = n - 64'd1;
        s = 0;
        while (d != 0 && !d[0]) begin
            d = d >> 1;
            s++;
        end
        for (k = 0; k < mrpt_pkg::NUM_BASES; k++) begin
            a = 64'(mrpt_pkg::MR_BASES[k]);
            if (n == a) return 1'b1;
            if (base_shows_composite(n, a, d, s)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] next_prime(input logic [63:0] start);
        logic [63:0] n;
        n = start | 64'd1;
        while (!predict_prime(n)) n = n + 64'd2;
        return n;
    endfunction

    // Random candidates: mostly moderate sizes, with primes and hard composites mixed in.
    function automatic logic [63:0] random_candidate();
        t_shape      shape;
        logic [63:0] k;
        shape = t_shape'($urandom_range(0, 6));
        case (shape)
            SHAPE_TINY: return 64'($urandom_range(0, 40));
            SHAPE_HALF: return 64'($urandom_range(0, 16'hFFFF));
            SHAPE_WORD: return {32'd0, $urandom};
            SHAPE_WIDE: return {$urandom, $urandom};
            SHAPE_SEMIPRIME: return next_prime(64'($urandom_range(3, 16'hFFFF)))
                                  * next_prime(64'($urandom_range(3, 16'hFFFF)));
            SHAPE_PRIME: return next_prime(64'($urandom_range(1 << 12, 1 << 20)));
            default: begin
                k = 64'($urandom_range(1, 300));
                return (6 * k + 1) * (12 * k + 1) * (18 * k + 1);
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= SHOW_MAX) $display("MISMATCH: %s", msg);
    endfunction

    // Offer one item, wait for it to be taken, then maybe go idle for a while.
    task automatic offer(input logic [63:0] cand, input logic want);
        t_verdict    v;
        int unsigned gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 58 : (idle_mode == IDLE_BOTH) ? 29 : 0;
        i_valid <= 1'b1;
        i_candidate <= cand;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        v.cand = cand;
        v.prime = want;
        pending_verdicts.insert(pending_verdicts.size(), v);
        items_sent++;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has been returned.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input t_idle mode);
        logic [63:0] c;
        int unsigned n;
        idle_mode = mode;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            c = random_candidate();
            offer(c, predict_prime(c));
        end
        drain();
    endtask

    // Result side: stall according to the phase, or hold off entirely during the burst.
    always @(posedge i_clk) begin
        if (hold_active) begin
            i_ready <= 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            i_ready <= ($urandom_range(0, 99) >= 58);
        end else if (idle_mode == IDLE_BOTH) begin
            i_ready <= ($urandom_range(0, 99) >= 29);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // One long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    initial begin : long_hold
        int unsigned held;
        wait (hold_request);
        @(posedge i_clk);
        hold_active <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Compare each returned item with the oldest pending verdict.
    always @(posedge i_clk) begin : check_result
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_is_prime === 1'b1) primes_seen++;
            if (pending_verdicts.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending, is_prime=%b",
                                        o_is_prime));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_is_prime !== want.prime) begin
                    note_mismatch($sformatf("candidate %0d: expected is_prime=%b, got %b",
                                            want.cand, want.prime, o_is_prime));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results pending.",
                     cycle_count, pending_verdicts.size());
            $display("miller_rabin_prime_test: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned r;
        logic [63:0] c;
        logic        want;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table of extremes, bases and strong liars.
        for (r = 0; r < NUM_ROWS; r++) begin
            c = directed_rows[r].cand;
            want = directed_rows[r].known ? directed_rows[r].prime : predict_prime(c);
            offer(c, want);
        end
        drain();

        // Burst of quick candidates while results are held back, so the input stalls.
        hold_request = 1'b1;
        for (r = 0; r < BURST_ITEMS; r++) begin
            c = 64'($urandom_range(0, 40));
            offer(c, predict_prime(c));
        end
        drain();

        // Random candidates under each idling pattern.
        run_phase(IDLE_NONE);
        run_phase(IDLE_SEND);
        run_phase(IDLE_RECV);
        run_phase(IDLE_BOTH);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Tested %0d candidates (table, held-off burst, four idling patterns),",
                 items_sent);
        $display("%0d results, %0d prime, %0d mismatches, %0d cycles.",
                 results_seen, primes_seen, mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("miller_rabin_prime_test: match");
        end else begin
            $display("miller_rabin_prime_test: mismatch");
        end
        $finish;
    end

endmodule
